/* design/gba_pkg.sv */
// ----------------------------------------------------------------------------
// gba_pkg
// Shared types and constants of the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gba_pkg;

  // Store geometry
  localparam int unsigned MaxGroups       = 32;
  localparam int unsigned MaxBpg          = 8192;
  localparam int unsigned WordsPerGroup   = MaxBpg / 32;
  localparam int unsigned BitmapWords     = MaxGroups * WordsPerGroup;
  localparam int unsigned WordAddrW       = $clog2(BitmapWords);
  localparam int unsigned GroupW          = $clog2(MaxGroups);
  localparam int unsigned WordInGroupW    = $clog2(WordsPerGroup);
  localparam int unsigned CountW          = 14;

  // Request codes
  localparam logic [2:0] ReqAlloc     = 3'd0;
  localparam logic [2:0] ReqFree      = 3'd1;
  localparam logic [2:0] ReqLoadWord  = 3'd2;
  localparam logic [2:0] ReqLoadGroup = 3'd3;
  localparam logic [2:0] ReqLoadTotal = 3'd4;

  // Status codes
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNoFree  = 2'd1;
  localparam logic [1:0] StIgnored = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CfgBpg    = 3'd0;
  localparam logic [2:0] CfgGroups = 3'd1;
  localparam logic [2:0] CfgTotal  = 3'd2;
  localparam logic [2:0] CfgFirst  = 3'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  group_index;
    logic [18:0] block_number;
    logic [12:0] word_index;
    logic [31:0] word_data;
    logic [31:0] count_value;
  } req_t;

  typedef struct packed {
    logic [18:0] result_block;
    logic [1:0]  status;
    logic [31:0] total_free;
  } rsp_t;

  // Effective configuration seen by the core
  typedef struct packed {
    logic [13:0] bpg;
    logic [5:0]  groups;
    logic [18:0] blocks_total;
    logic        first_block;
  } cfg_t;

endpackage

`default_nettype wire

/* design/gba_ram.sv */
// ----------------------------------------------------------------------------
// gba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/gba_core.sv */
// ----------------------------------------------------------------------------
// gba_core
// Sequencer of the allocator: owns the bitmap and count memories, runs the
// allocate scan, the free lookup and the loads one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire gba_pkg::req_t req_i,
  input  wire gba_pkg::cfg_t cfg_i,
  output logic               idle_o,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output gba_pkg::rsp_t      rsp_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PREP   = 10'b0000000010,
    S_CNT_RD = 10'b0000000100,
    S_CNT_CK = 10'b0000001000,
    S_WRD_RD = 10'b0000010000,
    S_WRD_CK = 10'b0000100000,
    S_F_DIV  = 10'b0001000000,
    S_F_RD   = 10'b0010000000,
    S_F_WR   = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_e;

  localparam int unsigned AW = gba_pkg::WordAddrW;
  localparam int unsigned GW = gba_pkg::GroupW;
  localparam int unsigned CW = gba_pkg::CountW;

  state_e state_q, state_d;

  logic [GW-1:0] grp_q, grp_d;        // current group
  logic [5:0]    visit_q, visit_d;    // groups visited
  logic [18:0]   start_q, start_d;    // first block of group (relative)
  logic [13:0]   size_q, size_d;      // blocks in group
  logic [13:0]   wo_q, wo_d;          // bit offset of current word
  logic [CW-1:0] cnt_q, cnt_d;        // group count in flight
  logic [18:0]   rem_q, rem_d;        // free: remainder of division
  logic [31:0]   total_q, total_d;
  logic [18:0]   res_blk_q, res_blk_d;
  logic [1:0]    res_st_q, res_st_d;

  // Memory ports
  logic          w_we, c_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [31:0]   w_wdata, w_rdata;
  logic [GW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata, c_rdata;

  gba_ram #(.Width(32), .Depth(gba_pkg::BitmapWords)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  gba_ram #(.Width(CW), .Depth(gba_pkg::MaxGroups)) u_counts (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Word address of the current word of the current group
  logic [AW-1:0] cur_waddr;
  assign cur_waddr = {grp_q, wo_q[12:5]};

  // Free lookup: word holding bit rem_q of group grp_q
  logic [AW-1:0] free_waddr;
  assign free_waddr = {grp_q, rem_q[12:5]};

  // Next group in the scan, wrapping at the group count
  logic [GW-1:0] grp_next;
  logic          scan_last;
  assign grp_next  = ({1'b0, grp_q} + 6'd1 == cfg_i.groups) ? '0 : grp_q + GW'(1);
  assign scan_last = (visit_q + 6'd1 == cfg_i.groups);

  // Size of the current group: last group takes the clamped remainder
  logic        grp_is_last;
  logic [18:0] tail;
  logic [13:0] grp_size;
  assign grp_is_last = ({1'b0, grp_q} == cfg_i.groups - 6'd1);
  assign tail        = cfg_i.blocks_total - start_q;
  always_comb begin
    if (!grp_is_last) begin
      grp_size = cfg_i.bpg;
    end else if (cfg_i.blocks_total <= start_q) begin
      grp_size = '0;
    end else if (tail > 19'(cfg_i.bpg)) begin
      grp_size = cfg_i.bpg;
    end else begin
      grp_size = tail[13:0];
    end
  end

  // Valid-bit mask of the current word and lowest clear bit
  logic [13:0] span;
  logic [31:0] mask, clear;
  logic [4:0]  low_bit;
  assign span  = size_q - wo_q;
  assign mask  = (span >= 14'd32) ? '1 : ((32'd1 << span[4:0]) - 32'd1);
  assign clear = ~w_rdata & mask;
  always_comb begin
    low_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (clear[i]) low_bit = 5'(i);
    end
  end

  // Relative block of a free request
  logic [18:0] free_rel;
  assign free_rel = req_i.block_number - 19'(cfg_i.first_block);

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    visit_d   = visit_q;
    start_d   = start_q;
    size_d    = size_q;
    wo_d      = wo_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    total_d   = total_q;
    res_blk_d = res_blk_q;
    res_st_d  = res_st_q;
    w_we      = 1'b0;
    w_waddr   = cur_waddr;
    w_wdata   = w_rdata;
    w_raddr   = cur_waddr;
    c_we      = 1'b0;
    c_waddr   = grp_q;
    c_wdata   = cnt_q;
    c_raddr   = grp_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_blk_d = '0;
          res_st_d  = gba_pkg::StDone;
          state_d   = S_RESP;
          case (req_i.req_type)
            gba_pkg::ReqAlloc: begin
              if (cfg_i.groups == '0 || cfg_i.bpg == '0) begin
                res_st_d = gba_pkg::StNoFree;
              end else begin
                grp_d   = req_i.group_index;
                visit_d = '0;
                state_d = S_PREP;
              end
            end
            gba_pkg::ReqFree: begin
              if (req_i.block_number < 19'(cfg_i.first_block) || cfg_i.bpg == '0 ||
                  cfg_i.groups == '0) begin
                res_st_d = gba_pkg::StIgnored;
              end else begin
                rem_d   = free_rel;
                grp_d   = '0;
                state_d = S_F_DIV;
              end
            end
            gba_pkg::ReqLoadWord: begin
              w_we    = 1'b1;
              w_waddr = req_i.word_index;
              w_wdata = req_i.word_data;
            end
            gba_pkg::ReqLoadGroup: begin
              c_we    = 1'b1;
              c_waddr = req_i.group_index;
              c_wdata = req_i.count_value[CW-1:0];
            end
            gba_pkg::ReqLoadTotal: begin
              total_d = req_i.count_value;
            end
            default: ;
          endcase
        end
      end

      // Start group modulo group count, by repeated subtraction
      S_PREP: begin
        if ({1'b0, grp_q} >= cfg_i.groups) begin
          grp_d = grp_q - cfg_i.groups[GW-1:0];
        end else begin
          state_d = S_CNT_RD;
        end
      end

      // Count read issued; group start computed
      S_CNT_RD: begin
        start_d = 19'(grp_q) * 19'(cfg_i.bpg);
        state_d = S_CNT_CK;
      end

      S_CNT_CK: begin
        cnt_d  = c_rdata;
        size_d = grp_size;
        wo_d   = '0;
        if (c_rdata == '0 || grp_size == '0) begin
          if (scan_last) begin
            res_st_d = gba_pkg::StNoFree;
            state_d  = S_RESP;
          end else begin
            grp_d   = grp_next;
            visit_d = visit_q + 6'd1;
            state_d = S_CNT_RD;
          end
        end else begin
          state_d = S_WRD_RD;
        end
      end

      S_WRD_RD: begin
        state_d = S_WRD_CK;
      end

      // Examine the word: take the lowest clear bit or move on
      S_WRD_CK: begin
        if (clear != '0) begin
          w_we      = 1'b1;
          w_wdata   = w_rdata | (32'd1 << low_bit);
          c_we      = 1'b1;
          c_wdata   = cnt_q - CW'(1);
          total_d   = total_q - 32'd1;
          res_blk_d = start_q + 19'(wo_q) + 19'(low_bit) + 19'(cfg_i.first_block);
          res_st_d  = gba_pkg::StDone;
          state_d   = S_RESP;
        end else if (wo_q + 14'd32 < size_q) begin
          wo_d    = wo_q + 14'd32;
          state_d = S_WRD_RD;
        end else if (scan_last) begin
          res_st_d = gba_pkg::StNoFree;
          state_d  = S_RESP;
        end else begin
          grp_d   = grp_next;
          visit_d = visit_q + 6'd1;
          state_d = S_CNT_RD;
        end
      end

      // Free: group by repeated subtraction, bounded by the group count
      S_F_DIV: begin
        if (rem_q < 19'(cfg_i.bpg)) begin
          state_d = S_F_RD;
        end else if ({1'b0, grp_q} + 6'd1 >= cfg_i.groups) begin
          res_st_d = gba_pkg::StIgnored;
          state_d  = S_RESP;
        end else begin
          rem_d = rem_q - 19'(cfg_i.bpg);
          grp_d = grp_q + GW'(1);
        end
      end

      S_F_RD: begin
        w_raddr = free_waddr;
        state_d = S_F_WR;
      end

      S_F_WR: begin
        w_we     = 1'b1;
        w_waddr  = free_waddr;
        w_wdata  = w_rdata & ~(32'd1 << rem_q[4:0]);
        c_we     = 1'b1;
        c_wdata  = c_rdata + CW'(1);
        total_d  = total_q + 32'd1;
        state_d  = S_RESP;
      end

      S_RESP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q     <= grp_d;
    visit_q   <= visit_d;
    start_q   <= start_d;
    size_q    <= size_d;
    wo_q      <= wo_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign rsp_valid_o  = (state_q == S_RESP);
  assign rsp_o.result_block = res_blk_q;
  assign rsp_o.status       = res_st_q;
  assign rsp_o.total_free   = total_q;

endmodule

`default_nettype wire

/* design/grouped_bitmap_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_top
// First-fit block allocator over grouped used-bit bitmaps with free counts.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir | accepted when
//  --------+---------------------------------------+-----+------------------
//  in      | in_valid_i, in_stall_o, in_item_i     | in  | valid & !stall
//  out     | out_valid_o, out_stall_i, out_item_o  | out | valid & !stall
//  cfg     | cfg_valid_i, cfg_ready_o, idx, data   | in  | valid & ready
//
//  One item at a time. A free finds its group by repeated subtraction; an
//  allocate first reduces the start group below the group count the same way,
//  then reads the count of each visited group and the bitmap words it scans.
//  No clearing pass after reset; memories hold garbage until loaded.
//  A finished item waits in the output register, so the next item is taken
//  while that one is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_bitmap_block_allocator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gba_pkg::req_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gba_pkg::rsp_t      out_item_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [18:0]   cfg_data_i
);

  logic [13:0] bpg_q;
  logic [5:0]  groups_q;
  logic [18:0] total_q;
  logic        first_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpg_q    <= 14'd8192;
      groups_q <= 6'd1;
      total_q  <= 19'd8192;
      first_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gba_pkg::CfgBpg:    bpg_q    <= cfg_data_i[13:0];
        gba_pkg::CfgGroups: groups_q <= cfg_data_i[5:0];
        gba_pkg::CfgTotal:  total_q  <= cfg_data_i;
        gba_pkg::CfgFirst:  first_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) configuration
  gba_pkg::cfg_t cfg;
  assign cfg.bpg          = (bpg_q > 14'(gba_pkg::MaxBpg)) ? 14'(gba_pkg::MaxBpg) : bpg_q;
  assign cfg.groups       = (groups_q > 6'(gba_pkg::MaxGroups)) ?
                            6'(gba_pkg::MaxGroups) : groups_q;
  assign cfg.blocks_total = total_q;
  assign cfg.first_block  = first_q;

  logic          idle, rsp_valid, rsp_ready, in_take;
  gba_pkg::rsp_t rsp;

  assign in_stall_o = !idle;
  assign in_take    = in_valid_i && idle;

  gba_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_take),
    .req_i       (in_item_i),
    .cfg_i       (cfg),
    .idle_o      (idle),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  // Output register
  logic          out_valid_q;
  gba_pkg::rsp_t out_item_q;
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_item_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the grouped bitmap block allocator. A local model of the
// bitmaps and the free counts predicts every answer. Each request produces
// one answer. The checker compares each answer from the block, field by
// field, with the oldest one predicted. Requests that would read bitmap
// words or group counts never loaded are replaced by the load they need.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Wpg = gba_pkg::WordsPerGroup;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gba_pkg::req_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gba_pkg::rsp_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = gba_pkg::CfgBpg;
  logic [18:0] cfg_data_i = '0;

  grouped_bitmap_block_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Local copy of the allocator state
  logic [31:0] bitmap_mem [gba_pkg::BitmapWords];
  bit          word_loaded [gba_pkg::BitmapWords];
  logic [13:0] grp_free [gba_pkg::MaxGroups];
  bit          grp_loaded [gba_pkg::MaxGroups];
  logic [31:0] total_free_m = '0;
  logic [13:0] cfg_bpg = 14'd8192;
  logic [5:0]  cfg_groups = 6'd1;
  logic [18:0] cfg_total = 19'd8192;
  logic        cfg_first = 1'b1;

  gba_pkg::rsp_t answer_q [$];
  int unsigned errors = 0;
  bit calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned eff_groups();
    return (cfg_groups > gba_pkg::MaxGroups) ? gba_pkg::MaxGroups : cfg_groups;
  endfunction

  function automatic int unsigned eff_bpg();
    return (cfg_bpg > gba_pkg::MaxBpg) ? gba_pkg::MaxBpg : cfg_bpg;
  endfunction

  // First-fit scan without side effects; reports the first unloaded entry it hits
  function automatic void scan_groups(input logic [4:0] pref, output bit found,
                                      output int unsigned grp, output int unsigned wd,
                                      output int unsigned bt, output bit defined,
                                      output int need_word, output int need_grp);
    int unsigned groups, bpg, size, start, span;
    logic [31:0] mask, clr;
    groups = eff_groups();
    bpg = eff_bpg();
    found = 0; defined = 1; need_word = -1; need_grp = -1;
    grp = 0; wd = 0; bt = 0;
    if (groups == 0 || bpg == 0) return;
    for (int unsigned g = 0; g < groups; g++) begin
      grp = (g + pref) % groups;
      if (!grp_loaded[grp]) begin
        defined = 0; need_grp = grp;
        return;
      end
      if (grp_free[grp] == 0) continue;
      size = bpg;
      if (grp == groups - 1) begin
        start = grp * bpg;
        size = (cfg_total > start) ? cfg_total - start : 0;
        if (size > bpg) size = bpg;
      end
      for (wd = 0; wd * 32 < size; wd++) begin
        if (!word_loaded[grp * Wpg + wd]) begin
          defined = 0; need_word = grp * Wpg + wd;
          return;
        end
        span = size - wd * 32;
        mask = (span >= 32) ? 32'hFFFF_FFFF : ((32'd1 << span) - 1);
        clr = ~bitmap_mem[grp * Wpg + wd] & mask;
        if (clr != 0) begin
          for (bt = 0; bt < 31 && !clr[bt]; bt++) ;
          found = 1;
          return;
        end
      end
    end
  endfunction

  // Locate the bit a free request touches
  function automatic void free_target(input int unsigned blk, output bit in_range,
                                      output int unsigned grp, output int unsigned idx,
                                      output int unsigned bt);
    int unsigned bpg, rel, bit_in_grp;
    bpg = eff_bpg();
    in_range = 0; grp = 0; idx = 0; bt = 0;
    if (blk < cfg_first || bpg == 0) return;
    rel = blk - cfg_first;
    grp = rel / bpg;
    if (grp >= eff_groups()) return;
    bit_in_grp = rel % bpg;
    idx = grp * Wpg + (bit_in_grp >> 5);
    bt = bit_in_grp & 31;
    in_range = 1;
  endfunction

  // Apply one request to the local state and return its answer
  function automatic gba_pkg::rsp_t allocator_step(input gba_pkg::req_t r);
    gba_pkg::rsp_t a;
    bit found, defined, in_range;
    int unsigned grp, wd, bt, idx;
    int need_word, need_grp;
    a.result_block = '0;
    a.status = gba_pkg::StDone;
    case (r.req_type)
      gba_pkg::ReqAlloc: begin
        scan_groups(r.group_index, found, grp, wd, bt, defined, need_word, need_grp);
        if (found) begin
          bitmap_mem[grp * Wpg + wd][bt] = 1'b1;
          grp_free[grp] = grp_free[grp] - 1;
          total_free_m = total_free_m - 1;
          a.result_block = 19'(grp * eff_bpg() + wd * 32 + bt + cfg_first);
        end else begin
          a.status = gba_pkg::StNoFree;
        end
      end
      gba_pkg::ReqFree: begin
        free_target(r.block_number, in_range, grp, idx, bt);
        if (in_range) begin
          bitmap_mem[idx][bt] = 1'b0;
          grp_free[grp] = grp_free[grp] + 1;
          total_free_m = total_free_m + 1;
        end else begin
          a.status = gba_pkg::StIgnored;
        end
      end
      gba_pkg::ReqLoadWord: begin
        bitmap_mem[r.word_index] = r.word_data;
        word_loaded[r.word_index] = 1'b1;
      end
      gba_pkg::ReqLoadGroup: begin
        grp_free[r.group_index] = r.count_value[13:0];
        grp_loaded[r.group_index] = 1'b1;
      end
      gba_pkg::ReqLoadTotal: total_free_m = r.count_value;
      default: ;
    endcase
    a.total_free = total_free_m;
    return a;
  endfunction

  // Offer one item until accepted, then maybe leave a gap
  task automatic send(input gba_pkg::req_t r);
    bit acc;
    in_valid_i <= 1'b1;
    in_item_i <= r;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    answer_q.push_back(allocator_step(r));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back writes; the caller drops it
  task automatic cfg_write(input logic [2:0] idx, input logic [18:0] val);
    bit acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    case (idx)
      gba_pkg::CfgBpg:    cfg_bpg = val[13:0];
      gba_pkg::CfgGroups: cfg_groups = val[5:0];
      gba_pkg::CfgTotal:  cfg_total = val;
      default:            cfg_first = val[0];
    endcase
  endtask

  function automatic gba_pkg::req_t rand_fields();
    gba_pkg::req_t r;
    r.req_type = gba_pkg::ReqAlloc;
    r.group_index = 5'($urandom);
    r.block_number = 19'($urandom);
    r.word_index = 13'($urandom);
    r.word_data = $urandom;
    r.count_value = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic gba_pkg::req_t load_word_req(input int unsigned idx);
    gba_pkg::req_t r;
    r = rand_fields();
    r.req_type = gba_pkg::ReqLoadWord;
    r.word_index = 13'(idx);
    r.word_data = rand_word();
    return r;
  endfunction

  function automatic gba_pkg::req_t load_group_req(input int unsigned g);
    gba_pkg::req_t r;
    r = rand_fields();
    r.req_type = gba_pkg::ReqLoadGroup;
    r.group_index = 5'(g);
    case ($urandom_range(0, 5))
      0: r.count_value = 0;
      1: r.count_value = $urandom;
      default: r.count_value = $urandom_range(1, 20);
    endcase
    return r;
  endfunction

  // Random request whose reads only reach loaded entries
  function automatic gba_pkg::req_t rand_req();
    gba_pkg::req_t r;
    bit found, defined, in_range;
    int unsigned grp, wd, bt, idx, pick, span;
    int need_word, need_grp;
    r = rand_fields();
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      r.req_type = gba_pkg::ReqAlloc;
      scan_groups(r.group_index, found, grp, wd, bt, defined, need_word, need_grp);
      if (!defined) r = (need_word >= 0) ? load_word_req(need_word) : load_group_req(need_grp);
    end else if (pick < 78) begin
      r.req_type = gba_pkg::ReqFree;
      span = eff_groups() * eff_bpg();
      if ($urandom_range(0, 4) != 0 && span != 0)
        r.block_number = 19'($urandom_range(0, span - 1) + cfg_first);
      free_target(r.block_number, in_range, grp, idx, bt);
      if (in_range && !grp_loaded[grp]) r = load_group_req(grp);
      else if (in_range && !word_loaded[idx]) r = load_word_req(idx);
    end else if (pick < 86) begin
      r = load_word_req($urandom_range(0, 5) == 0 ?
                        $urandom_range(0, gba_pkg::BitmapWords - 1) :
                        $urandom_range(0, eff_groups() * Wpg) % gba_pkg::BitmapWords);
    end else if (pick < 91) begin
      r = load_group_req($urandom_range(0, gba_pkg::MaxGroups - 1));
    end else if (pick < 94) begin
      r.req_type = gba_pkg::ReqLoadTotal;
    end else begin
      r.req_type = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // Reconfigure while idle, then load counts and first words of each group
  task automatic set_layout(input logic [13:0] bpg, input logic [5:0] groups,
                            input logic [18:0] total, input logic first);
    gba_pkg::req_t r;
    wait_idle();
    cfg_write(gba_pkg::CfgBpg, 19'(bpg));
    cfg_write(gba_pkg::CfgGroups, 19'(groups));
    cfg_write(gba_pkg::CfgTotal, total);
    cfg_write(gba_pkg::CfgFirst, 19'(first));
    cfg_valid_i <= 1'b0;
    r = rand_fields();
    r.req_type = gba_pkg::ReqLoadTotal;
    r.count_value = $urandom_range(0, 1000);
    send(r);
    for (int unsigned g = 0; g < eff_groups(); g++) begin
      send(load_group_req(g));
      send(load_word_req(g * Wpg));
    end
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send(rand_req());
  endtask

  // Extremes and special cases under the reset layout
  task automatic test_directed();
    gba_pkg::req_t r;
    r = '0;
    r.req_type = gba_pkg::ReqLoadTotal; r.count_value = 32'hFFFF_FFFF; send(r);
    r.req_type = gba_pkg::ReqLoadGroup; r.group_index = 0; r.count_value = 2; send(r);
    r.req_type = gba_pkg::ReqLoadWord; r.word_index = 0; r.word_data = 32'hFFFF_FFFE; send(r);
    r.word_index = 1; r.word_data = 32'hFFFF_FFFF; send(r);
    r.word_index = 2; r.word_data = 32'h0; send(r);
    r.word_index = 13'h1FFF; r.word_data = 32'hFFFF_FFFF; send(r);
    r.req_type = gba_pkg::ReqAlloc; r.group_index = 0; send(r);
    r.group_index = 5'h1F; send(r);
    // count now zero: group skipped, no free block
    send(r);
    r.req_type = gba_pkg::ReqLoadGroup; r.group_index = 0; r.count_value = 32'hFFFF_FFFF;
    send(r);
    r.req_type = gba_pkg::ReqLoadTotal; send(r);
    // both counts wrap upward
    r.req_type = gba_pkg::ReqFree; r.block_number = 19'd1; send(r);
    r.block_number = 19'd0; send(r);
    r.block_number = 19'd8193; send(r);
    r.block_number = 19'h7FFFF; send(r);
    r.req_type = gba_pkg::ReqLoadTotal; r.count_value = 0; send(r);
    r.req_type = gba_pkg::ReqAlloc; r.group_index = 0; send(r);
    for (int t = 5; t <= 7; t++) begin
      r = '1;
      r.req_type = 3'(t);
      send(r);
    end
  endtask

  task automatic test_layouts();
    set_layout(14'd8, 6'd1, 19'd8, 1'b0);          run_random(130);
    set_layout(14'd8, 6'd32, 19'd256, 1'b1);       run_random(150);
    set_layout(14'd37, 6'd5, 19'd150, 1'b1);       run_random(150);
    set_layout(14'd8, 6'd3, 19'd1, 1'b0);          run_random(90);
    set_layout(14'd0, 6'd4, 19'd100, 1'b0);        run_random(40);
    set_layout(14'd100, 6'd0, 19'd100, 1'b1);      run_random(40);
    set_layout(14'h3FFF, 6'd2, 19'd20000, 1'b1);   run_random(100);
    set_layout(14'd64, 6'h3F, 19'h7FFFF, 1'b0);    run_random(130);
    set_layout(14'd8192, 6'd32, 19'd262144, 1'b1); run_random(120);
  endtask

  // Output held off long while items keep coming
  task automatic test_backpressure();
    set_layout(14'd16, 6'd4, 19'd60, 1'b1);
    hold_left = 300;
    run_random(60);
  endtask

  // Sender waits for every answer mid-stream
  task automatic test_drain_pause();
    run_random(30);
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    run_random(30);
  endtask

  task automatic test_steady();
    calm = 1'b1;
    set_layout(14'd24, 6'd8, 19'd180, 1'b0);
    run_random(150);
  endtask

  // Output side: random stall bursts, long hold, answer checking
  always begin : rx_proc
    bit take;
    gba_pkg::rsp_t got, exp;
    @(negedge clk_i);
    take = out_valid_o && !out_stall_i;
    got = out_item_o;
    @(posedge clk_i);
    if (take) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected answer %p", $realtime, got);
        errors++;
      end else begin
        exp = answer_q.pop_front();
        if (got.result_block !== exp.result_block) begin
          $display("%0t: result_block expected %0d actual %0d", $realtime,
                   exp.result_block, got.result_block);
          errors++;
        end
        if (got.status !== exp.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp.status, got.status);
          errors++;
        end
        if (got.total_free !== exp.total_free) begin
          $display("%0t: total_free expected %0h actual %0h", $realtime,
                   exp.total_free, got.total_free);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < gba_pkg::BitmapWords; i++) word_loaded[i] = 1'b0;
    for (int i = 0; i < gba_pkg::MaxGroups; i++) grp_loaded[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_layouts();
    test_backpressure();
    test_drain_pause();
    test_steady();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/gba_pkg.sv
design/gba_ram.sv
design/gba_core.sv
design/grouped_bitmap_block_allocator_top.sv
sim/tb_top.sv
